// ===== design/f2b_pkg.sv =====
// Shared constants, types and status codes for the fraction to fixed point converter.
package f2b_pkg;

  localparam int FRACTION_BITS = 32;
  // quotient bits made, counting the sign position in signed mode
  localparam int STEP_COUNT = (FRACTION_BITS > 32) ? 32 : FRACTION_BITS;
  // left shift that aligns the made bits to the top of the word
  localparam int QSHIFT = 32 - STEP_COUNT;
  // magnitudes after halving never exceed 2^31 - 1
  localparam int MAG_W = 31;

  localparam logic [31:0] SAT_UNSIGNED = 32'hFFFF_FFFF;
  localparam logic [31:0] SAT_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG      = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } f2b_status_t;

  typedef struct packed {
    logic              sgn;     // signed Q1.31 mode
    logic              neg;     // operand signs differ
    f2b_status_t       status;
    logic [MAG_W-1:0]  rem;
    logic [MAG_W-1:0]  dvs;
    logic [31:0]       quo;
  } f2b_item_t;

endpackage

// ===== design/f2b_in_if.sv =====
// Input channel: action and operands with valid/ready handshake.
interface f2b_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] numerator;
  logic [31:0] denominator;

  modport source (output valid, action, numerator, denominator, input ready);
  modport sink   (input valid, action, numerator, denominator, output ready);
endinterface

// ===== design/f2b_out_if.sv =====
// Result channel: fraction and status with valid/ready handshake.
interface f2b_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fraction;
  logic [1:0]  status;

  modport source (output valid, fraction, status, input ready);
  modport sink   (input valid, fraction, status, output ready);
endinterface

// ===== design/f2b_prep.sv =====
// Operand stage: halving, sign and magnitude, error classification.
module f2b_prep
  import f2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic        action,
  input  logic [31:0] numerator,
  input  logic [31:0] denominator,
  output logic        valid_o,
  output f2b_item_t   item_o
);

  logic        valid_r;
  f2b_item_t   item_r;
  f2b_item_t   item_nxt;

  logic        u_half;
  logic [31:0] un, ud;
  logic        s_half;
  logic [31:0] sn, sd;
  logic [31:0] sn_abs, sd_abs;
  logic [MAG_W-1:0] a, b;

  always_comb begin
    // unsigned: halve when either operand has its top bit set
    u_half = numerator[31] | denominator[31];
    un = u_half ? {1'b0, numerator[31:1]}   : numerator;
    ud = u_half ? {1'b0, denominator[31:1]} : denominator;

    // signed: out of [-2^30, 2^30) when the top two bits differ; halve toward zero
    s_half = (numerator[31] ^ numerator[30]) | (denominator[31] ^ denominator[30]);
    sn = numerator   + {31'd0, numerator[31]};
    sd = denominator + {31'd0, denominator[31]};
    sn = s_half ? {sn[31], sn[31:1]} : numerator;
    sd = s_half ? {sd[31], sd[31:1]} : denominator;
    sn_abs = sn[31] ? (~sn + 32'd1) : sn;
    sd_abs = sd[31] ? (~sd + 32'd1) : sd;

    if (action) begin
      a = sn_abs[MAG_W-1:0];
      b = sd_abs[MAG_W-1:0];
    end else begin
      a = un[MAG_W-1:0];
      b = ud[MAG_W-1:0];
    end

    item_nxt.sgn = action;
    item_nxt.neg = action & (sn[31] ^ sd[31]);
    if (b == '0) begin
      item_nxt.status = ST_DIV0;
    end else if (a >= b) begin
      item_nxt.status = ST_SAT;
    end else begin
      item_nxt.status = ST_OK;
    end
    item_nxt.rem = a;
    item_nxt.dvs = b;
    item_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

// ===== design/f2b_div_stage.sv =====
// Registered restoring step: a quotient bit, or signed pass-through.
module f2b_div_stage
  import f2b_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      final_step,
  input  logic      valid_i,
  input  f2b_item_t item_i,
  output logic      valid_o,
  output f2b_item_t item_o
);

  logic        valid_r;
  f2b_item_t   item_r;
  f2b_item_t   item_nxt;
  logic [MAG_W:0] shifted;
  logic [MAG_W:0] diff;
  logic        ge;
  logic        active;

  always_comb begin
    // signed mode makes one bit fewer: the last step passes through
    active  = !(final_step && item_i.sgn);
    shifted = {item_i.rem, 1'b0};
    diff    = shifted - {1'b0, item_i.dvs};
    ge      = shifted >= {1'b0, item_i.dvs};
    item_nxt = item_i;
    if (active) begin
      item_nxt.rem = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      item_nxt.quo = {item_i.quo[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

// ===== design/f2b_post.sv =====
// Output stage: alignment, sign inversion, saturation and error codes.
module f2b_post
  import f2b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        valid_i,
  input  f2b_item_t   item_i,
  output logic        valid_o,
  output logic [31:0] fraction,
  output logic [1:0]  status
);

  logic        valid_r;
  logic [31:0] fraction_r, fraction_nxt;
  logic [1:0]  status_r;
  logic [31:0] aligned;

  always_comb begin
    aligned = item_i.quo << QSHIFT;
    case (item_i.status)
      ST_DIV0: fraction_nxt = '0;
      ST_SAT: begin
        if (!item_i.sgn) begin
          fraction_nxt = SAT_UNSIGNED;
        end else begin
          fraction_nxt = item_i.neg ? SAT_NEG : SAT_POS;
        end
      end
      default: fraction_nxt = item_i.neg ? ~aligned : aligned;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fraction_r <= fraction_nxt;
      status_r   <= item_i.status;
    end
  end

  assign valid_o  = valid_r;
  assign fraction = fraction_r;
  assign status   = status_r;

endmodule

// ===== design/fraction_to_binary_fixed_point.sv =====
// Fraction to binary fixed point converter: pipelined restoring divider.
//
// in_ch carries action, numerator and denominator; out_ch returns fraction
// and status. Action 0 yields an unsigned 32-bit fraction, action 1 a
// Q1.31 value (one's complement when the operand signs differ). Status
// reports a saturated improper fraction or a zero denominator.
//
// Throughput: one item per cycle while out_ch is not stalled. Stages: one
// operand stage, STEP_COUNT division step stages (one quotient bit each,
// the last passing through in signed mode), one output stage.
//
// When out_ch is stalled with a result waiting, the whole pipeline holds,
// bubbles included, and in_ch.ready drops; nothing is lost or repeated.
// With no result waiting the pipeline moves every cycle.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline starts
// empty and accepts items as soon as reset is released.
module fraction_to_binary_fixed_point
  import f2b_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  f2b_in_if.sink    in_ch,
  f2b_out_if.source out_ch
);

  logic      adv;
  logic      vld [0:STEP_COUNT];
  f2b_item_t stg [0:STEP_COUNT];

  // pipeline moves unless a result waits on a stalled receiver
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  f2b_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_ch.valid),
    .action      (in_ch.action),
    .numerator   (in_ch.numerator),
    .denominator (in_ch.denominator),
    .valid_o     (vld[0]),
    .item_o      (stg[0])
  );

  for (genvar k = 0; k < STEP_COUNT; k++) begin : g_step
    f2b_div_stage u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .final_step (1'(k == STEP_COUNT - 1)),
      .valid_i    (vld[k]),
      .item_i     (stg[k]),
      .valid_o    (vld[k+1]),
      .item_o     (stg[k+1])
    );
  end

  f2b_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_i  (vld[STEP_COUNT]),
    .item_i   (stg[STEP_COUNT]),
    .valid_o  (out_ch.valid),
    .fraction (out_ch.fraction),
    .status   (out_ch.status)
  );

endmodule

// ===== tb/fraction_to_binary_fixed_point_tb.sv =====
// Self-checking testbench for the fraction to binary fixed point converter.
`timescale 1ns / 100ps

module fraction_to_binary_fixed_point_tb;
  import f2b_pkg::*;

  localparam logic ACT_UNSIGNED = 1'b0;
  localparam logic ACT_SIGNED   = 1'b1;

  localparam int QBITS        = (FRACTION_BITS > 32) ? 32 : FRACTION_BITS;
  localparam int DRAIN_CYCLES = QBITS + 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 725;
  localparam int MAX_WAIT     = 12;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT_A    = 60;
  localparam int HOLD_AT_B    = 400;
  localparam int MAX_PRINTED  = 20;

  localparam longint SIGNED_SPAN = 64'sh4000_0000;

  localparam logic [31:0] CORNERS [9] = '{
    32'h0000_0000, 32'h0000_0001, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hBFFF_FFFF, 32'hC000_0000, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic        action;
    logic [31:0] numerator;
    logic [31:0] denominator;
  } conv_req_t;

  typedef struct packed {
    logic [31:0] fraction;
    f2b_status_t status;
  } conv_res_t;

  logic clk;
  logic rst_n;

  f2b_in_if  in_ch();
  f2b_out_if out_ch();

  fraction_to_binary_fixed_point dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  conv_req_t pending_conversions[$];
  conv_res_t awaited_fractions[$];

  int errors        = 0;
  int items_sent    = 0;
  int signed_sent   = 0;
  int items_offered = 0;
  int results_taken = 0;
  int idle_cycles   = 0;
  int status_seen[3] = '{0, 0, 0};
  bit in_fire       = 1'b0;
  bit out_fire      = 1'b0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_left     = 0;
  conv_req_t next_req;
  conv_res_t want_res;
  conv_res_t got_res;

  // restoring division: one quotient bit per step, from bit 'top' down
  function automatic logic [31:0] restore_bits(logic [63:0] rem, logic [63:0] dvs,
                                               int top, int nbits);
    logic [31:0] q;
    q = '0;
    for (int k = 0; k < nbits && k <= top; k++) begin
      rem = rem << 1;
      if (rem >= dvs) begin
        q[top-k] = 1'b1;
        rem = rem - dvs;
      end
    end
    return q;
  endfunction

  function automatic conv_res_t convert_fraction(conv_req_t req);
    conv_res_t   res;
    logic [31:0] un, ud;
    longint      sn, sd;
    logic [63:0] mag_n, mag_d;
    logic        neg;
    res.fraction = '0;
    res.status   = ST_OK;
    if (req.action == ACT_UNSIGNED) begin
      un = req.numerator;
      ud = req.denominator;
      if (un[31] || ud[31]) begin
        un = un >> 1;
        ud = ud >> 1;
      end
      if (ud == '0) begin
        res.status = ST_DIV0;
      end else if (un >= ud) begin
        res.status   = ST_SAT;
        res.fraction = SAT_UNSIGNED;
      end else begin
        res.fraction = restore_bits({32'd0, un}, {32'd0, ud}, 31, QBITS);
      end
    end else begin
      sn = longint'($signed(req.numerator));
      sd = longint'($signed(req.denominator));
      // halving truncates toward zero; signs are taken afterwards
      if (sn < -SIGNED_SPAN || sn >= SIGNED_SPAN || sd < -SIGNED_SPAN || sd >= SIGNED_SPAN) begin
        sn = sn / 2;
        sd = sd / 2;
      end
      neg   = (sn < 0) != (sd < 0);
      mag_n = (sn < 0) ? -sn : sn;
      mag_d = (sd < 0) ? -sd : sd;
      if (mag_d == '0) begin
        res.status = ST_DIV0;
      end else if (mag_n >= mag_d) begin
        res.status   = ST_SAT;
        res.fraction = neg ? SAT_NEG : SAT_POS;
      end else begin
        res.fraction = restore_bits(mag_n, mag_d, 30, QBITS - 1);
        if (neg) res.fraction = ~res.fraction;
      end
    end
    return res;
  endfunction

  // some stretches run with no waits at all
  function automatic int draw_wait(int n);
    return ((n % 100) < 30) ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic add_conversion(logic act, logic [31:0] n, logic [31:0] d);
    conv_req_t req;
    req.action      = act;
    req.numerator   = n;
    req.denominator = d;
    pending_conversions.push_back(req);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sample both channels, predict on accept, check on result, watchdog
  always @(posedge clk) begin
    in_fire  = rst_n && in_ch.valid && in_ch.ready;
    out_fire = rst_n && out_ch.valid && out_ch.ready;
    if (in_fire) begin
      next_req.action      = in_ch.action;
      next_req.numerator   = in_ch.numerator;
      next_req.denominator = in_ch.denominator;
      want_res = convert_fraction(next_req);
      awaited_fractions.push_back(want_res);
      items_sent++;
      if (next_req.action == ACT_SIGNED) signed_sent++;
      status_seen[want_res.status]++;
    end
    if (out_fire) begin
      results_taken++;
      if (awaited_fractions.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.fraction, 32'd0);
      end else begin
        got_res  = awaited_fractions.pop_front();
        if (out_ch.fraction !== got_res.fraction)
          report_mismatch("fraction", out_ch.fraction, got_res.fraction);
        if (out_ch.status !== got_res.status)
          report_mismatch("status", {30'd0, out_ch.status}, {30'd0, got_res.status});
      end
    end
    if (rst_n) begin
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("fraction_to_binary_fixed_point_tb: done, errors");
        $finish;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_ch.valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_conversions.size() != 0) begin
        next_req = pending_conversions.pop_front();
        in_ch.action      <= next_req.action;
        in_ch.numerator   <= next_req.numerator;
        in_ch.denominator <= next_req.denominator;
        in_ch.valid       <= 1'b1;
        items_offered++;
        // keep offering back to back while the receiver holds off
        if (results_taken == HOLD_AT_A || results_taken == HOLD_AT_B) send_gap = 0;
        else send_gap = draw_wait(items_offered);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_fire) begin
        recv_gap = draw_wait(results_taken + 50);
        if (results_taken == HOLD_AT_A || results_taken == HOLD_AT_B) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic        act;
    logic [31:0] n, d, mag, tmp;
    int          pick;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_UNSIGNED;
    in_ch.numerator   = '0;
    in_ch.denominator = '0;
    out_ch.ready      = 1'b0;

    // unsigned: plain, halving, near one, improper, zero denominator
    add_conversion(ACT_UNSIGNED, 32'h0000_0001, 32'h0000_0003);
    add_conversion(ACT_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF);
    add_conversion(ACT_UNSIGNED, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    add_conversion(ACT_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_conversion(ACT_UNSIGNED, 32'h0000_0005, 32'h0000_0000);
    add_conversion(ACT_UNSIGNED, 32'h0000_0000, 32'h0000_0000);
    add_conversion(ACT_UNSIGNED, 32'h0000_0001, 32'h0000_0001);
    add_conversion(ACT_UNSIGNED, 32'h0000_0001, 32'h8000_0000);
    add_conversion(ACT_UNSIGNED, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    // halving turns a denominator of one into zero
    add_conversion(ACT_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001);
    // signed: all sign pairs
    add_conversion(ACT_SIGNED, 32'h0000_0001, 32'h0000_0003);
    add_conversion(ACT_SIGNED, 32'hFFFF_FFFF, 32'h0000_0003);
    add_conversion(ACT_SIGNED, 32'h0000_0001, 32'hFFFF_FFFD);
    add_conversion(ACT_SIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
    // zero over a negative denominator gives inverted zero
    add_conversion(ACT_SIGNED, 32'h0000_0000, 32'hFFFF_FFFB);
    add_conversion(ACT_SIGNED, 32'h0000_0000, 32'h0000_0000);
    add_conversion(ACT_SIGNED, 32'h0000_0005, 32'h0000_0003);
    add_conversion(ACT_SIGNED, 32'hFFFF_FFFB, 32'h0000_0003);
    add_conversion(ACT_SIGNED, 32'h8000_0000, 32'h7FFF_FFFF);
    // minus one halves to zero and then counts as non-negative
    add_conversion(ACT_SIGNED, 32'hFFFF_FFFF, 32'h4000_0000);
    add_conversion(ACT_SIGNED, 32'h3FFF_FFFF, 32'hC000_0000);
    add_conversion(ACT_SIGNED, 32'hC000_0000, 32'h4000_0000);
    add_conversion(ACT_SIGNED, 32'h0000_0001, 32'h0000_0001);
    add_conversion(ACT_SIGNED, 32'hFFFF_FFFF, 32'h0000_0001);
    add_conversion(ACT_SIGNED, 32'h7FFF_FFFF, 32'h8000_0000);

    // mostly proper fractions over a spread of magnitudes, plus noise
    repeat (RANDOM_ITEMS) begin
      act  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (act == ACT_UNSIGNED) begin
        d = $urandom >> $urandom_range(0, 31);
        if (d == '0) d = 32'd1;
        n = $urandom % d;
      end else begin
        mag = $urandom >> $urandom_range(1, 31);
        if (mag == '0) mag = 32'd1;
        n = $urandom % mag;
        if ($urandom_range(0, 1)) n = -n;
        d = $urandom_range(0, 1) ? -mag : mag;
      end
      case (pick)
        7: begin
          n = $urandom;
          d = $urandom;
        end
        8: begin
          n = CORNERS[$urandom_range(0, 8)];
          d = ($urandom_range(0, 3) == 0) ? 32'd0 : CORNERS[$urandom_range(0, 8)];
        end
        9: begin
          tmp = n;
          n   = d;
          d   = tmp;
        end
        default: ;
      endcase
      add_conversion(act, n, d);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_conversions.size() != 0 || in_ch.valid || awaited_fractions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d conversions (%0d signed, %0d unsigned), %0d results checked",
             items_sent, signed_sent, items_sent - signed_sent, results_taken);
    $display("summary: %0d in range, %0d saturated, %0d zero denominator, %0d mismatches",
             status_seen[ST_OK], status_seen[ST_SAT], status_seen[ST_DIV0], errors);
    if (errors == 0) begin
      $display("fraction_to_binary_fixed_point_tb: done, clean");
    end else begin
      $display("fraction_to_binary_fixed_point_tb: done, errors");
    end
    $finish;
  end

endmodule
